// ===== rtl/ciu_pkg.sv =====
// Shared types and constants for the centered integer upscaler.
package ciu_pkg;

  localparam int unsigned PIX_W      = 16;
  localparam int unsigned ADDR_W     = 24;
  localparam int unsigned SCR_W      = 13;
  localparam int unsigned SRC_W      = 11;
  localparam int unsigned SCALE_W    = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned DIV_CNT_W  = 4;

  localparam logic [SCR_W-1:0] SCREEN_W_RST = 13'd640;
  localparam logic [SCR_W-1:0] SCREEN_H_RST = 13'd480;
  localparam logic [SRC_W-1:0] SOURCE_W_RST = 11'd96;
  localparam logic [SRC_W-1:0] SOURCE_H_RST = 11'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_W = 2'd0,
    CFG_SCREEN_H = 2'd1,
    CFG_SOURCE_W = 2'd2,
    CFG_SOURCE_H = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic capture;
    logic pos_clear;
    logic div_start;
    logic div_sel_y;
    logic cap_x;
    logic cap_y;
    logic scale_en;
    logic size_en;
    logic offs_en;
    logic orig_en;
    logic wrap_en;
    logic base_en;
    logic out_load;
    logic out_nofit;
  } ciu_cmd_t;

  typedef struct packed {
    logic div_done;
    logic scale_zero;
    logic last_write;
  } ciu_status_t;

endpackage

// ===== rtl/ciu_if.sv =====
// Request channel interfaces: source pixels in, framebuffer writes out.
interface ciu_pix_if;
  logic                        valid;
  logic                        ready;
  logic [ciu_pkg::PIX_W-1:0]   pixel_in;
  logic                        frame_start;

  modport source (output valid, pixel_in, frame_start, input ready);
  modport sink   (input valid, pixel_in, frame_start, output ready);
endinterface

interface ciu_wr_if;
  logic                        valid;
  logic                        ready;
  logic [ciu_pkg::ADDR_W-1:0]  write_address;
  logic [ciu_pkg::PIX_W-1:0]   pixel_out;
  logic                        no_fit;
  logic                        last;

  modport source (output valid, write_address, pixel_out, no_fit, last, input ready);
  modport sink   (input valid, write_address, pixel_out, no_fit, last, output ready);
endinterface

// ===== rtl/centered_integer_upscaler_top.sv =====
// Top level of the centered integer nearest-neighbor upscaler.
// A pixel without frame start first wraps its position and forms the block's
// base address in the WRAP and BASE states, then makes one framebuffer write
// per cycle through the single output register while the write side is ready.
// A frame start first runs both screen/source divisions through one shared
// bit-serial divider, then the placement steps scale, size, offset and origin.
// A no-fit pixel makes one write flagged no_fit. One pixel is in work at a time;
// the next is taken once its last write is in the output register.
module centered_integer_upscaler_top #(
  parameter int unsigned SCALE_LIMIT = 6
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ciu_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ciu_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  ciu_pix_if.sink                          pix_i,
  ciu_wr_if.source                         wr_o
);

  ciu_pkg::ciu_cmd_t    cmd;
  ciu_pkg::ciu_status_t status;

  ciu_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (pix_i.valid),
    .in_frame_start_i (pix_i.frame_start),
    .in_ready_o       (pix_i.ready),
    .out_valid_o      (wr_o.valid),
    .out_ready_i      (wr_o.ready),
    .status_i         (status),
    .cmd_o            (cmd)
  );

  ciu_datapath #(
    .SCALE_LIMIT (SCALE_LIMIT)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .pixel_in_i      (pix_i.pixel_in),
    .cmd_i           (cmd),
    .status_o        (status),
    .write_address_o (wr_o.write_address),
    .pixel_out_o     (wr_o.pixel_out),
    .no_fit_o        (wr_o.no_fit),
    .last_o          (wr_o.last)
  );

endmodule

// ===== rtl/ciu_divider.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module ciu_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ciu_pkg::SCR_W-1:0]   dividend_i,
  input  logic [ciu_pkg::SRC_W-1:0]   divisor_i,
  output logic [ciu_pkg::SCR_W-1:0]   quotient_o,
  output logic                        done_o
);

  logic                            busy_q;
  logic                            done_q;
  logic [ciu_pkg::DIV_CNT_W-1:0]   cnt_q;
  logic [ciu_pkg::SCR_W-1:0]       num_q;
  logic [ciu_pkg::SRC_W-1:0]       den_q;
  logic [ciu_pkg::SRC_W-1:0]       rem_q;
  logic [ciu_pkg::SRC_W:0]         rem_sh;
  logic [ciu_pkg::SRC_W:0]         diff;
  logic                            ge;

  assign rem_sh = {rem_q, num_q[ciu_pkg::SCR_W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};
  assign diff   = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == ciu_pkg::DIV_CNT_W'(ciu_pkg::SCR_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      den_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[ciu_pkg::SRC_W-1:0] : rem_sh[ciu_pkg::SRC_W-1:0];
      num_q <= {num_q[ciu_pkg::SCR_W-2:0], ge};
    end
  end

  assign quotient_o = num_q;
  assign done_o     = done_q;

endmodule

// ===== rtl/ciu_ctrl.sv =====
// Controller: sequences placement, address setup and write emission.
module ciu_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_frame_start_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  ciu_pkg::ciu_status_t  status_i,
  output ciu_pkg::ciu_cmd_t     cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIVX,
    S_WAITX,
    S_DIVY,
    S_WAITY,
    S_SCALE,
    S_SIZE,
    S_OFFS,
    S_ORIG,
    S_WRAP,
    S_BASE,
    S_EMIT,
    S_NOFIT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   accept;
  logic   out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o           = '0;
    cmd_o.capture   = accept;
    cmd_o.pos_clear = accept && in_frame_start_i;
    cmd_o.div_start = (state_q == S_DIVX) || (state_q == S_DIVY);
    cmd_o.div_sel_y = (state_q == S_DIVY);
    cmd_o.cap_x     = (state_q == S_WAITX) && status_i.div_done;
    cmd_o.cap_y     = (state_q == S_WAITY) && status_i.div_done;
    cmd_o.scale_en  = (state_q == S_SCALE);
    cmd_o.size_en   = (state_q == S_SIZE);
    cmd_o.offs_en   = (state_q == S_OFFS);
    cmd_o.orig_en   = (state_q == S_ORIG);
    cmd_o.wrap_en   = (state_q == S_WRAP);
    cmd_o.base_en   = (state_q == S_BASE);
    cmd_o.out_load  = ((state_q == S_EMIT) || (state_q == S_NOFIT)) && out_free;
    cmd_o.out_nofit = (state_q == S_NOFIT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (in_frame_start_i) begin
              state_q <= S_DIVX;
            end else if (status_i.scale_zero) begin
              state_q <= S_NOFIT;
            end else begin
              state_q <= S_WRAP;
            end
          end
        end
        S_DIVX:  state_q <= S_WAITX;
        S_WAITX: if (status_i.div_done) state_q <= S_DIVY;
        S_DIVY:  state_q <= S_WAITY;
        S_WAITY: if (status_i.div_done) state_q <= S_SCALE;
        S_SCALE: state_q <= S_SIZE;
        S_SIZE:  state_q <= S_OFFS;
        S_OFFS:  state_q <= S_ORIG;
        S_ORIG:  state_q <= status_i.scale_zero ? S_NOFIT : S_WRAP;
        S_WRAP:  state_q <= S_BASE;
        S_BASE:  state_q <= S_EMIT;
        S_EMIT: begin
          if (cmd_o.out_load && status_i.last_write) begin
            state_q <= S_IDLE;
          end
        end
        S_NOFIT: if (cmd_o.out_load) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/ciu_datapath.sv =====
// Datapath: configuration, placement math, position and write address generation.
module ciu_datapath #(
  parameter int unsigned SCALE_LIMIT = 6
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ciu_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ciu_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [ciu_pkg::PIX_W-1:0]        pixel_in_i,
  input  ciu_pkg::ciu_cmd_t                cmd_i,
  output ciu_pkg::ciu_status_t             status_o,
  output logic [ciu_pkg::ADDR_W-1:0]       write_address_o,
  output logic [ciu_pkg::PIX_W-1:0]        pixel_out_o,
  output logic                             no_fit_o,
  output logic                             last_o
);

  localparam int unsigned SCR_W   = ciu_pkg::SCR_W;
  localparam int unsigned SRC_W   = ciu_pkg::SRC_W;
  localparam int unsigned SCALE_W = ciu_pkg::SCALE_W;
  localparam int unsigned ADDR_W  = ciu_pkg::ADDR_W;
  localparam int unsigned PROD_W  = SRC_W + SCALE_W;

  logic [SCR_W-1:0]            scr_w_q, scr_h_q;
  logic [SRC_W-1:0]            src_w_q, src_h_q;
  logic [ciu_pkg::PIX_W-1:0]   pix_q;
  logic [SCR_W-1:0]            qx_q, qy_q;
  logic [SCALE_W-1:0]          scale_q;
  logic [PROD_W-1:0]           dw_q, dh_q;
  logic [SCR_W-1:0]            ox_q, oy_q;
  logic [ADDR_W-1:0]           origin_q;
  logic [SRC_W-1:0]            col_q, row_q;
  logic [PROD_W-1:0]           rs_q, cs_q;
  logic [ADDR_W-1:0]           row_base_q;
  logic [SCALE_W-1:0]          dx_q, dy_q;
  logic [ADDR_W-1:0]           out_addr_q;
  logic [ciu_pkg::PIX_W-1:0]   out_pix_q;
  logic                        out_nofit_q, out_last_q;

  logic [SCR_W-1:0]            div_quot;
  logic                        div_done;
  logic [SCR_W-1:0]            s_min;
  logic [SCALE_W-1:0]          scale_d;
  logic                        src_zero;
  logic [2*SCR_W-1:0]          org_prod;
  logic [PROD_W+SCR_W-1:0]     rs_prod;
  logic [SRC_W-1:0]            col_w, row_w;
  logic [SRC_W-1:0]            col_inc, row_inc;
  logic [SCALE_W-1:0]          scale_m1;
  logic                        dx_end, last_write;

  ciu_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (cmd_i.div_sel_y ? scr_h_q : scr_w_q),
    .divisor_i  (cmd_i.div_sel_y ? src_h_q : src_w_q),
    .quotient_o (div_quot),
    .done_o     (div_done)
  );

  assign src_zero = (src_w_q == '0) || (src_h_q == '0);
  assign s_min    = (qx_q < qy_q) ? qx_q : qy_q;

  always_comb begin
    if (src_zero || (s_min == '0)) begin
      scale_d = '0;
    end else if (s_min > SCR_W'(SCALE_LIMIT)) begin
      scale_d = SCALE_W'(SCALE_LIMIT);
    end else begin
      scale_d = s_min[SCALE_W-1:0];
    end
  end

  assign org_prod = (2*SCR_W)'(oy_q) * (2*SCR_W)'(scr_w_q);
  assign rs_prod  = (PROD_W+SCR_W)'(rs_q) * (PROD_W+SCR_W)'(scr_w_q);
  assign col_w    = (col_q >= src_w_q) ? '0 : col_q;
  assign row_w    = (row_q >= src_h_q) ? '0 : row_q;
  assign col_inc  = col_q + 1'b1;
  assign row_inc  = row_q + 1'b1;
  assign scale_m1 = scale_q - 1'b1;
  assign dx_end   = (dx_q == scale_m1);
  assign last_write = dx_end && (dy_q == scale_m1);

  assign status_o.div_done   = div_done;
  assign status_o.scale_zero = (scale_q == '0);
  assign status_o.last_write = last_write;

  // configuration, placement and position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_w_q  <= ciu_pkg::SCREEN_W_RST;
      scr_h_q  <= ciu_pkg::SCREEN_H_RST;
      src_w_q  <= ciu_pkg::SOURCE_W_RST;
      src_h_q  <= ciu_pkg::SOURCE_H_RST;
      scale_q  <= '0;
      origin_q <= '0;
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        case (ciu_pkg::cfg_reg_e'(cfg_idx_i))
          ciu_pkg::CFG_SCREEN_W: scr_w_q <= cfg_data_i[SCR_W-1:0];
          ciu_pkg::CFG_SCREEN_H: scr_h_q <= cfg_data_i[SCR_W-1:0];
          ciu_pkg::CFG_SOURCE_W: src_w_q <= cfg_data_i[SRC_W-1:0];
          ciu_pkg::CFG_SOURCE_H: src_h_q <= cfg_data_i[SRC_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.scale_en) scale_q <= scale_d;
      if (cmd_i.orig_en) begin
        origin_q <= (scale_q == '0) ? '0
                  : org_prod[ADDR_W-1:0] + {{(ADDR_W-SCR_W){1'b0}}, ox_q};
      end
      if (cmd_i.pos_clear) begin
        col_q <= '0;
        row_q <= '0;
      end else if (cmd_i.wrap_en) begin
        col_q <= col_w;
        row_q <= row_w;
      end else if (cmd_i.out_load && !cmd_i.out_nofit && last_write) begin
        if (col_inc >= src_w_q) begin
          col_q <= '0;
          row_q <= (row_inc >= src_h_q) ? '0 : row_inc;
        end else begin
          col_q <= col_inc;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) pix_q <= pixel_in_i;
    if (cmd_i.cap_x) qx_q <= div_quot;
    if (cmd_i.cap_y) qy_q <= div_quot;
    if (cmd_i.size_en) begin
      dw_q <= PROD_W'(scale_q) * PROD_W'(src_w_q);
      dh_q <= PROD_W'(scale_q) * PROD_W'(src_h_q);
    end
    if (cmd_i.offs_en) begin
      ox_q <= {1'b0, scr_w_q[SCR_W-1:1]} - dw_q[SCR_W:1];
      oy_q <= {1'b0, scr_h_q[SCR_W-1:1]} - dh_q[SCR_W:1];
    end
    if (cmd_i.wrap_en) begin
      rs_q <= PROD_W'(row_w) * PROD_W'(scale_q);
      cs_q <= PROD_W'(col_w) * PROD_W'(scale_q);
    end
    if (cmd_i.base_en) begin
      row_base_q <= origin_q + rs_prod[ADDR_W-1:0]
                  + {{(ADDR_W-PROD_W){1'b0}}, cs_q};
      dx_q <= '0;
      dy_q <= '0;
    end
    if (cmd_i.out_load) begin
      if (cmd_i.out_nofit) begin
        out_addr_q  <= '0;
        out_pix_q   <= '0;
        out_nofit_q <= 1'b1;
        out_last_q  <= 1'b1;
      end else begin
        out_addr_q  <= row_base_q + {{(ADDR_W-SCALE_W){1'b0}}, dx_q};
        out_pix_q   <= pix_q;
        out_nofit_q <= 1'b0;
        out_last_q  <= last_write;
        if (dx_end) begin
          dx_q       <= '0;
          dy_q       <= dy_q + 1'b1;
          row_base_q <= row_base_q + {{(ADDR_W-SCR_W){1'b0}}, scr_w_q};
        end else begin
          dx_q <= dx_q + 1'b1;
        end
      end
    end
  end

  assign write_address_o = out_addr_q;
  assign pixel_out_o     = out_pix_q;
  assign no_fit_o        = out_nofit_q;
  assign last_o          = out_last_q;

endmodule

// ===== tb/centered_integer_upscaler_top_tb.sv =====
// Testbench for the centered integer upscaler: directed table, then random frames.
`timescale 1ns / 100ps

module centered_integer_upscaler_top_tb;
  import ciu_pkg::*;

  localparam int unsigned SCALE_LIMIT = 6;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  pix;
    logic              no_fit;
    logic              last;
  } fb_write_t;

  typedef enum logic {STEP_PIX, STEP_CFG} step_e;

  typedef struct packed {
    step_e                 kind;
    cfg_reg_e              idx;
    logic [CFG_DATA_W-1:0] data;
    logic [PIX_W-1:0]      pix;
    logic                  fs;
    logic                  typed;
    fb_write_t             want;
  } dir_row_t;

  localparam fb_write_t NO_FIT = '{24'd0, 16'd0, 1'b1, 1'b1};
  localparam fb_write_t NONE   = '0;

  localparam dir_row_t PLAN [40] = '{
    '{STEP_PIX, CFG_SCREEN_W, 13'd0,    16'hFFFF, 1'b0, 1'b1, NO_FIT},
    '{STEP_PIX, CFG_SCREEN_W, 13'd0,    16'h0000, 1'b0, 1'b1, NO_FIT},
    '{STEP_PIX, CFG_SCREEN_W, 13'd0,    16'hA5A5, 1'b1, 1'b0, NONE},
    '{STEP_PIX, CFG_SCREEN_W, 13'd0,    16'h5A5A, 1'b0, 1'b0, NONE},
    '{STEP_PIX, CFG_SCREEN_W, 13'd0,    16'h1234, 1'b1, 1'b0, NONE},
    '{STEP_CFG, CFG_SOURCE_W, 13'd0,    16'h0000, 1'b0, 1'b0, NONE},
    '{STEP_PIX, CFG_SCREEN_W, 13'd0,    16'hFFFF, 1'b1, 1'b1, NO_FIT},
    '{STEP_PIX, CFG_SCREEN_W, 13'd0,    16'h8000, 1'b0, 1'b1, NO_FIT},
    '{STEP_CFG, CFG_SOURCE_W, 13'd1,    16'h0000, 1'b0, 1'b0, NONE},
    '{STEP_CFG, CFG_SOURCE_H, 13'd1,    16'h0000, 1'b0, 1'b0, NONE},
    '{STEP_CFG, CFG_SCREEN_W, 13'd0,    16'h0000, 1'b0, 1'b0, NONE},
    '{STEP_PIX, CFG_SCREEN_W, 13'd0,    16'h7FFF, 1'b1, 1'b1, NO_FIT},
    '{STEP_CFG, CFG_SCREEN_W, 13'd1,    16'h0000, 1'b0, 1'b0, NONE},
    '{STEP_CFG, CFG_SCREEN_H, 13'd1,    16'h0000, 1'b0, 1'b0, NONE},
    '{STEP_PIX, CFG_SCREEN_W, 13'd0,    16'h0001, 1'b1, 1'b1, '{24'd0, 16'h0001, 1'b0, 1'b1}},
    '{STEP_PIX, CFG_SCREEN_W, 13'd0,    16'hFFFE, 1'b0, 1'b1, '{24'd0, 16'hFFFE, 1'b0, 1'b1}},
    '{STEP_CFG, CFG_SCREEN_W, 13'd8191, 16'h0000, 1'b0, 1'b0, NONE},
    '{STEP_CFG, CFG_SCREEN_H, 13'd8191, 16'h0000, 1'b0, 1'b0, NONE},
    '{STEP_PIX, CFG_SCREEN_W, 13'd0,    16'hC3C3, 1'b1, 1'b0, NONE},
    '{STEP_CFG, CFG_SCREEN_W, 13'd4096, 16'h0000, 1'b0, 1'b0, NONE},
    '{STEP_CFG, CFG_SCREEN_H, 13'd4096, 16'h0000, 1'b0, 1'b0, NONE},
    '{STEP_CFG, CFG_SOURCE_W, 13'd2047, 16'h0000, 1'b0, 1'b0, NONE},
    '{STEP_CFG, CFG_SOURCE_H, 13'h1FFF, 16'h0000, 1'b0, 1'b0, NONE},
    '{STEP_PIX, CFG_SCREEN_W, 13'd0,    16'h00FF, 1'b1, 1'b0, NONE},
    '{STEP_PIX, CFG_SCREEN_W, 13'd0,    16'hFF00, 1'b0, 1'b0, NONE},
    '{STEP_CFG, CFG_SCREEN_W, 13'd3,    16'h0000, 1'b0, 1'b0, NONE},
    '{STEP_CFG, CFG_SOURCE_W, 13'd4,    16'h0000, 1'b0, 1'b0, NONE},
    '{STEP_PIX, CFG_SCREEN_W, 13'd0,    16'h3C3C, 1'b1, 1'b1, NO_FIT},
    '{STEP_CFG, CFG_SCREEN_W, 13'd20,   16'h0000, 1'b0, 1'b0, NONE},
    '{STEP_CFG, CFG_SCREEN_H, 13'd20,   16'h0000, 1'b0, 1'b0, NONE},
    '{STEP_CFG, CFG_SOURCE_H, 13'h1804, 16'h0000, 1'b0, 1'b0, NONE},
    '{STEP_PIX, CFG_SCREEN_W, 13'd0,    16'h1111, 1'b1, 1'b0, NONE},
    '{STEP_PIX, CFG_SCREEN_W, 13'd0,    16'h2222, 1'b0, 1'b0, NONE},
    '{STEP_PIX, CFG_SCREEN_W, 13'd0,    16'h3333, 1'b0, 1'b0, NONE},
    '{STEP_CFG, CFG_SOURCE_W, 13'd2,    16'h0000, 1'b0, 1'b0, NONE},
    '{STEP_PIX, CFG_SCREEN_W, 13'd0,    16'h4444, 1'b0, 1'b0, NONE},
    '{STEP_CFG, CFG_SCREEN_W, 13'd32,   16'h0000, 1'b0, 1'b0, NONE},
    '{STEP_PIX, CFG_SCREEN_W, 13'd0,    16'h5555, 1'b0, 1'b0, NONE},
    '{STEP_CFG, CFG_SOURCE_H, 13'd1,    16'h0000, 1'b0, 1'b0, NONE},
    '{STEP_PIX, CFG_SCREEN_W, 13'd0,    16'h6666, 1'b0, 1'b0, NONE}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  ciu_pix_if pix_if ();
  ciu_wr_if  wr_if ();

  centered_integer_upscaler_top #(
    .SCALE_LIMIT(SCALE_LIMIT)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .pix_i     (pix_if),
    .wr_o      (wr_if)
  );

  // shadow registers and placement state
  logic [SCR_W-1:0] scr_w = SCREEN_W_RST;
  logic [SCR_W-1:0] scr_h = SCREEN_H_RST;
  logic [SRC_W-1:0] src_w = SOURCE_W_RST;
  logic [SRC_W-1:0] src_h = SOURCE_H_RST;
  int unsigned       src_col = 0;
  int unsigned       src_row = 0;
  int unsigned       scale = 0;
  longint unsigned   origin = 0;

  fb_write_t fb_writes_due [$];
  int        mismatches = 0;
  bit        tx_calm = 1'b0;
  bit        rx_calm = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #15_000_000;
    $display("centered_integer_upscaler_top_tb NOT OK");
    $finish;
  end

  task automatic report(input string msg);
    mismatches++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  function automatic void place_image();
    int unsigned sw, sh, iw, ih, sx, sy, s, ox, oy;
    sw = scr_w;
    sh = scr_h;
    iw = src_w;
    ih = src_h;
    scale = 0;
    origin = 0;
    if (iw == 0 || ih == 0) return;
    sx = sw / iw;
    sy = sh / ih;
    s = (sx < sy) ? sx : sy;
    if (s < 1) return;
    if (s > SCALE_LIMIT) s = SCALE_LIMIT;
    ox = (sw >> 1) - ((s * iw) >> 1);
    oy = (sh >> 1) - ((s * ih) >> 1);
    scale = s;
    origin = longint'(oy) * sw + ox;
  endfunction

  function automatic void upscale_pixel(input logic [PIX_W-1:0] pix, input logic fs,
                                        ref fb_write_t q [$]);
    longint unsigned base, a;
    fb_write_t w;
    if (fs) begin
      src_col = 0;
      src_row = 0;
      place_image();
    end
    if (scale == 0) begin
      q.push_back(NO_FIT);
      return;
    end
    if (src_col >= src_w) src_col = 0;
    if (src_row >= src_h) src_row = 0;
    base = origin + longint'(src_row) * scale * scr_w + longint'(src_col) * scale;
    for (int unsigned dy = 0; dy < scale; dy++) begin
      for (int unsigned dx = 0; dx < scale; dx++) begin
        a = base + longint'(dy) * scr_w + dx;
        w.addr   = a[ADDR_W-1:0];
        w.pix    = pix;
        w.no_fit = 1'b0;
        w.last   = (dy == scale - 1) && (dx == scale - 1);
        q.push_back(w);
      end
    end
    src_col++;
    if (src_col >= src_w) begin
      src_col = 0;
      src_row++;
      if (src_row >= src_h) src_row = 0;
    end
  endfunction

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_SCREEN_W: scr_w = data;
      CFG_SCREEN_H: scr_h = data;
      CFG_SOURCE_W: src_w = data[SRC_W-1:0];
      CFG_SOURCE_H: src_h = data[SRC_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs,
                            input logic typed, input fb_write_t want);
    fb_write_t scratch [$];
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 12);
    cfg_we_i <= 1'b0;
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_if.valid       <= 1'b1;
    pix_if.pixel_in    <= pix;
    pix_if.frame_start <= fs;
    do @(posedge clk_i); while (!pix_if.ready);
    if (typed) begin
      upscale_pixel(pix, fs, scratch);
      fb_writes_due.push_back(want);
    end else begin
      upscale_pixel(pix, fs, fb_writes_due);
    end
  endtask

  task automatic wait_idle();
    pix_if.valid <= 1'b0;
    while (fb_writes_due.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [SRC_W-1:0] pick_source();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return 11'd2047;
      2:       return SRC_W'($urandom_range(7, 2047));
      default: return SRC_W'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic logic [SCR_W-1:0] pick_screen(input int unsigned src);
    int unsigned v;
    case ($urandom_range(0, 11))
      0:       v = 0;
      1:       v = 8191;
      2:       v = $urandom_range(0, 8191);
      default: v = src * $urandom_range(1, 8) + $urandom_range(0, (src > 0) ? src - 1 : 0);
    endcase
    if (v > 8191) v = 8191;
    return v[SCR_W-1:0];
  endfunction

  always @(posedge clk_i) begin : check_writes
    fb_write_t got, want;
    if (wr_if.valid && wr_if.ready) begin
      got = '{wr_if.write_address, wr_if.pixel_out, wr_if.no_fit, wr_if.last};
      if (fb_writes_due.size() == 0) begin
        report($sformatf("write with none due: addr %h pix %h no_fit %b last %b",
                         got.addr, got.pix, got.no_fit, got.last));
      end else begin
        want = fb_writes_due.pop_front();
        if (got.addr !== want.addr)
          report($sformatf("write_address %h, want %h", got.addr, want.addr));
        if (got.pix !== want.pix)
          report($sformatf("pixel_out %h, want %h at %h", got.pix, want.pix, want.addr));
        if (got.no_fit !== want.no_fit)
          report($sformatf("no_fit %b, want %b at %h", got.no_fit, want.no_fit, want.addr));
        if (got.last !== want.last)
          report($sformatf("last %b, want %b at %h", got.last, want.last, want.addr));
      end
    end
  end

  // write side: per-request stall
  initial begin
    int gap;
    wr_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = rx_calm ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        wr_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      wr_if.ready <= 1'b1;
      do @(posedge clk_i); while (!wr_if.valid);
    end
  end

  initial begin
    int sent;
    int burst;
    bit first;
    logic [SRC_W-1:0] sw, sh;
    logic fs;
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= CFG_SCREEN_W;
    cfg_data_i         <= '0;
    pix_if.valid       <= 1'b0;
    pix_if.pixel_in    <= '0;
    pix_if.frame_start <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (PLAN[i]) begin
      if (PLAN[i].kind == STEP_CFG) begin
        wait_idle();
        write_reg(PLAN[i].idx, PLAN[i].data);
      end else begin
        send_pixel(PLAN[i].pix, PLAN[i].fs, PLAN[i].typed, PLAN[i].want);
      end
    end

    sent = 0;
    first = 1'b1;
    while (sent < 260) begin
      wait_idle();
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      sw = pick_source();
      sh = pick_source();
      if (first || $urandom_range(0, 3) != 0)
        write_reg(CFG_SCREEN_W, pick_screen(sw));
      if (first || $urandom_range(0, 3) != 0)
        write_reg(CFG_SCREEN_H, pick_screen(sh));
      // upper data bits are don't-care for the source registers
      if (first || $urandom_range(0, 3) != 0)
        write_reg(CFG_SOURCE_W, {2'($urandom_range(0, 3)), sw});
      if (first || $urandom_range(0, 3) != 0)
        write_reg(CFG_SOURCE_H, {2'($urandom_range(0, 3)), sh});
      first = 1'b0;
      burst = $urandom_range(4, 24);
      for (int j = 0; j < burst; j++) begin
        fs = (j == 0 && $urandom_range(0, 5) != 0) || ($urandom_range(0, 19) == 0);
        send_pixel(PIX_W'($urandom_range(0, 65535)), fs, 1'b0, NONE);
      end
      sent += burst;
    end

    wait_idle();
    repeat (60) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("centered_integer_upscaler_top_tb OK");
    end else begin
      $display("centered_integer_upscaler_top_tb NOT OK");
    end
    $finish;
  end

endmodule
